// File: sv/stl_pkg.sv
`default_nettype none

package stl_pkg;

  // scanner modes
  typedef enum logic [3:0] {
    MODE_IDLE    = 4'd0,
    MODE_IDENT   = 4'd1,
    MODE_NUMBER  = 4'd2,
    MODE_CHARLIT = 4'd3,
    MODE_STRING  = 4'd4,
    MODE_SQUOTE  = 4'd5,
    MODE_COLON   = 4'd6,
    MODE_BINARY  = 4'd7,
    MODE_MINUS   = 4'd8,
    MODE_COMMENT = 4'd9,
    MODE_ERROR   = 4'd10
  } mode_t;

  typedef enum logic [1:0] {
    KIND_CHAR = 2'd0,
    KIND_END  = 2'd1,
    KIND_ERR  = 2'd2
  } kind_t;

  typedef enum logic [3:0] {
    TOK_IDENT   = 4'd0,
    TOK_KEYWORD = 4'd1,
    TOK_NUMBER  = 4'd2,
    TOK_CHAR    = 4'd3,
    TOK_STRING  = 4'd4,
    TOK_COLON   = 4'd5,
    TOK_ASSIGN  = 4'd6,
    TOK_RETURN  = 4'd7,
    TOK_LBRACK  = 4'd8,
    TOK_RBRACK  = 4'd9,
    TOK_LPAREN  = 4'd10,
    TOK_RPAREN  = 4'd11,
    TOK_PERIOD  = 4'd12,
    TOK_SEMI    = 4'd13,
    TOK_BINARY  = 4'd14,
    TOK_END     = 4'd15
  } tok_t;

  typedef enum logic [1:0] {
    ERR_INVALID = 2'd0,
    ERR_CHARLIT = 2'd1,
    ERR_STRLIT  = 2'd2
  } err_t;

  localparam int unsigned MaxRes = 3;

  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_EQUAL  = 8'h3D;
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_CARET  = 8'h5E;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_SEMI   = 8'h3B;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_LBRACK = 8'h5B;
  localparam logic [7:0] CH_RBRACK = 8'h5D;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_PERIOD = 8'h2E;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] ch;
    tok_t       ttype;
    err_t       err;
    logic       last;
  } res_t;

  typedef struct packed {
    logic [1:0]          cnt;
    res_t [MaxRes-1:0]   arr;
  } res_list_t;

  typedef struct packed {
    res_list_t l;
    mode_t     m;
  } step_t;

  function automatic logic is_alpha(logic [7:0] c);
    return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A);
  endfunction

  function automatic logic is_digit(logic [7:0] c);
    return c >= 8'h30 && c <= 8'h39;
  endfunction

  function automatic logic is_alnum(logic [7:0] c);
    return is_alpha(c) || is_digit(c);
  endfunction

  function automatic logic is_space(logic [7:0] c);
    return c == 8'h20 || (c >= 8'h09 && c <= 8'h0D);
  endfunction

  function automatic logic is_binary(logic [7:0] c);
    return c == 8'h21 || c == 8'h25 || c == 8'h26 || c == 8'h2A || c == 8'h2B ||
           c == 8'h2C || c == 8'h2F || c == 8'h3C || c == CH_EQUAL || c == 8'h3E ||
           c == 8'h3F || c == 8'h40 || c == 8'h5C || c == 8'h7C || c == 8'h7E ||
           c == CH_MINUS;
  endfunction

  function automatic res_t res_char(logic [7:0] c);
    res_t r;
    r = '0;
    r.kind = KIND_CHAR;
    r.ch   = c;
    return r;
  endfunction

  function automatic res_t res_end(tok_t t);
    res_t r;
    r = '0;
    r.kind  = KIND_END;
    r.ttype = t;
    return r;
  endfunction

  function automatic res_t res_err(err_t e);
    res_t r;
    r = '0;
    r.kind = KIND_ERR;
    r.err  = e;
    return r;
  endfunction

  function automatic res_list_t push(res_list_t l, res_t e);
    res_list_t o;
    o = l;
    if (l.cnt < 2'(MaxRes)) begin
      o.arr[l.cnt] = e;
      o.cnt = l.cnt + 2'd1;
    end
    return o;
  endfunction

  // scan a character from the idle mode, appending to the list passed in
  function automatic step_t scan_idle(res_list_t l, logic [7:0] c);
    step_t s;
    logic  single;
    tok_t  st;
    s.l    = l;
    s.m    = MODE_IDLE;
    single = 1'b1;
    case (c)
      CH_CARET:  st = TOK_RETURN;
      CH_LBRACK: st = TOK_LBRACK;
      CH_RBRACK: st = TOK_RBRACK;
      CH_LPAREN: st = TOK_LPAREN;
      CH_RPAREN: st = TOK_RPAREN;
      CH_PERIOD: st = TOK_PERIOD;
      CH_SEMI:   st = TOK_SEMI;
      default: begin
        st     = TOK_END;
        single = 1'b0;
      end
    endcase
    if (is_space(c)) begin
      s.m = MODE_IDLE;
    end else if (c == CH_DQUOTE) begin
      s.m = MODE_COMMENT;
    end else if (is_alpha(c)) begin
      s.l = push(l, res_char(c));
      s.m = MODE_IDENT;
    end else if (is_digit(c)) begin
      s.l = push(l, res_char(c));
      s.m = MODE_NUMBER;
    end else if (c == CH_DOLLAR) begin
      s.m = MODE_CHARLIT;
    end else if (c == CH_SQUOTE) begin
      s.m = MODE_STRING;
    end else if (c == CH_COLON) begin
      s.l = push(l, res_char(c));
      s.m = MODE_COLON;
    end else if (single) begin
      s.l = push(push(l, res_char(c)), res_end(st));
      s.m = MODE_IDLE;
    end else if (c == CH_MINUS) begin
      s.l = push(l, res_char(c));
      s.m = MODE_MINUS;
    end else if (is_binary(c)) begin
      s.l = push(l, res_char(c));
      s.m = MODE_BINARY;
    end else begin
      s.l = push(l, res_err(ERR_INVALID));
      s.m = MODE_ERROR;
    end
    return s;
  endfunction

  // one input transaction: results in order and the mode left behind
  function automatic step_t lex_step(mode_t m, logic [7:0] c, logic eoi);
    step_t     s;
    res_list_t none;
    none = '0;
    s.l  = '0;
    s.m  = MODE_IDLE;
    if (eoi) begin
      case (m)
        MODE_IDENT:   s.l = push(push(none, res_end(TOK_IDENT)), res_end(TOK_END));
        MODE_NUMBER:  s.l = push(push(none, res_end(TOK_NUMBER)), res_end(TOK_END));
        MODE_CHARLIT: s.l = push(none, res_err(ERR_CHARLIT));
        MODE_STRING:  s.l = push(none, res_err(ERR_STRLIT));
        MODE_SQUOTE:  s.l = push(push(none, res_end(TOK_STRING)), res_end(TOK_END));
        MODE_COLON:   s.l = push(push(none, res_end(TOK_COLON)), res_end(TOK_END));
        MODE_BINARY,
        MODE_MINUS:   s.l = push(push(none, res_end(TOK_BINARY)), res_end(TOK_END));
        MODE_ERROR:   s.l = none;
        default:      s.l = push(none, res_end(TOK_END));
      endcase
    end else begin
      case (m)
        MODE_IDENT: begin
          if (is_alnum(c)) begin
            s.l = push(none, res_char(c));
            s.m = MODE_IDENT;
          end else if (c == CH_COLON) begin
            s.l = push(push(none, res_char(c)), res_end(TOK_KEYWORD));
          end else begin
            s = scan_idle(push(none, res_end(TOK_IDENT)), c);
          end
        end
        MODE_NUMBER: begin
          if (is_alnum(c)) begin
            s.l = push(none, res_char(c));
            s.m = MODE_NUMBER;
          end else begin
            s = scan_idle(push(none, res_end(TOK_NUMBER)), c);
          end
        end
        MODE_CHARLIT: s.l = push(push(none, res_char(c)), res_end(TOK_CHAR));
        MODE_STRING: begin
          if (c == CH_SQUOTE) begin
            s.m = MODE_SQUOTE;
          end else begin
            s.l = push(none, res_char(c));
            s.m = MODE_STRING;
          end
        end
        MODE_SQUOTE: begin
          if (c == CH_SQUOTE) begin
            s.l = push(none, res_char(c));
            s.m = MODE_STRING;
          end else begin
            s = scan_idle(push(none, res_end(TOK_STRING)), c);
          end
        end
        MODE_COLON: begin
          if (c == CH_EQUAL) begin
            s.l = push(push(none, res_char(c)), res_end(TOK_ASSIGN));
          end else begin
            s = scan_idle(push(none, res_end(TOK_COLON)), c);
          end
        end
        MODE_MINUS: begin
          if (is_digit(c)) begin
            s.l = push(none, res_char(c));
            s.m = MODE_NUMBER;
          end else if (is_binary(c)) begin
            s.l = push(push(none, res_char(c)), res_end(TOK_BINARY));
          end else begin
            s = scan_idle(push(none, res_end(TOK_BINARY)), c);
          end
        end
        MODE_BINARY: begin
          if (is_binary(c)) begin
            s.l = push(push(none, res_char(c)), res_end(TOK_BINARY));
          end else begin
            s = scan_idle(push(none, res_end(TOK_BINARY)), c);
          end
        end
        MODE_COMMENT: s.m = (c == CH_DQUOTE) ? MODE_IDLE : MODE_COMMENT;
        MODE_ERROR:   s.m = MODE_ERROR;
        default:      s = scan_idle(none, c);
      endcase
    end
    return s;
  endfunction

endpackage

`default_nettype wire

// File: sv/smalltalk_token_lexer.sv
// channel | direction | handshake            | payload
// in      | input     | in_valid / in_ready  | char_code, end_of_input
// out     | output    | out_valid / out_ready| item_kind, token_char, token_type,
//         |           |                      | error_kind, last
// an input transaction waits in the input register until the result buffer is free, then the scanner logic
// turns it into zero to three results in the result buffer, drained one per cycle while out_ready is high
// a transaction with n results holds the result side until all n are drained;
// one-result characters stream at one per cycle while out_ready stays high
// a character that gives no result (whitespace, comment text) leaves the buffer empty
// rst is synchronous: scanner back to idle, both registers empty
// out_ready low holds the buffer; the input register still takes one transaction
`default_nettype none

module smalltalk_token_lexer (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [7:0] char_code,
  input  wire logic       end_of_input,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [1:0]      item_kind,
  output logic [7:0]      token_char,
  output logic [3:0]      token_type,
  output logic [1:0]      error_kind,
  output logic            last
);
  import stl_pkg::*;

  // input register
  logic       in_full;
  logic [7:0] in_char;
  logic       in_eoi;

  // scanner mode
  mode_t mode;
  mode_t mode_next;

  // result buffer
  logic              buf_valid;
  logic [1:0]        buf_cnt;
  logic [1:0]        rd_idx;
  res_t [MaxRes-1:0] buf_arr;

  step_t     step;
  res_list_t bundle;
  res_t      head;
  logic      drain_last;
  logic      buf_free;
  logic      advance;

  // scanner logic on the registered transaction
  always_comb begin
    step = lex_step(mode, in_char, in_eoi);
  end

  // next mode
  always_comb begin
    mode_next = mode;
    if (advance) begin
      mode_next = step.m;
    end
  end

  // result bundle, with last flagged on the final entry
  always_comb begin
    bundle = step.l;
    if (bundle.cnt != 2'd0) begin
      bundle.arr[bundle.cnt - 2'd1].last = 1'b1;
    end
  end

  assign head       = buf_arr[rd_idx];
  assign out_valid  = buf_valid;
  assign item_kind  = head.kind;
  assign token_char = head.ch;
  assign token_type = head.ttype;
  assign error_kind = head.err;
  assign last       = head.last;

  // buffer is free when empty or when its final entry goes out this cycle
  assign drain_last = buf_valid && out_ready && head.last;
  assign buf_free   = !buf_valid || drain_last;
  assign advance    = in_full && buf_free;
  assign in_ready   = !in_full || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (in_ready) begin
      in_full <= in_valid;
    end
    if (in_ready && in_valid) begin
      in_char <= char_code;
      in_eoi  <= end_of_input;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= MODE_IDLE;
    end else begin
      mode <= mode_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      buf_valid <= 1'b0;
      buf_cnt   <= 2'd0;
      rd_idx    <= 2'd0;
    end else if (advance) begin
      // transactions with no result leave the buffer empty
      buf_valid <= bundle.cnt != 2'd0;
      buf_cnt   <= bundle.cnt;
      rd_idx    <= 2'd0;
    end else if (drain_last) begin
      buf_valid <= 1'b0;
    end else if (buf_valid && out_ready) begin
      rd_idx <= rd_idx + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      buf_arr <= bundle.arr;
    end
  end

`ifndef SYNTHESIS
  // end of input always leaves the scanner idle
  a_eoi_idle: assert property (@(posedge clk) disable iff (rst)
    advance && in_eoi |=> mode == MODE_IDLE)
    else $error("scanner not idle after end of input");

  // characters after an error are swallowed
  a_error_swallow: assert property (@(posedge clk) disable iff (rst)
    advance && !in_eoi && mode == MODE_ERROR |=> !buf_valid && mode == MODE_ERROR)
    else $error("character after error produced a result");

  // read pointer stays inside the loaded bundle
  a_rd_in_range: assert property (@(posedge clk) disable iff (rst)
    buf_valid |-> rd_idx < buf_cnt && buf_cnt != 2'd0)
    else $error("result read pointer out of range");

  // only the final entry of a bundle carries last
  a_last_at_end: assert property (@(posedge clk) disable iff (rst)
    buf_valid |-> (head.last == (rd_idx == buf_cnt - 2'd1)))
    else $error("last flag does not match bundle end");
`endif

endmodule

`default_nettype wire

// File: tb/smalltalk_token_lexer_tb.sv
`timescale 1ns / 100ps

module smalltalk_token_lexer_tb;
  import stl_pkg::*;

  // one expected result as it should leave the output channel
  typedef struct packed {
    kind_t      kind;
    logic [7:0] ch;
    tok_t       ttype;
    err_t       err;
    logic       last;
  } lex_res_t;

  // one input transaction; rows with fixed set carry their results typed in
  typedef struct packed {
    logic                   eoi;
    logic [7:0]             ch;
    logic                   fixed;
    logic [1:0]             nres;
    lex_res_t [MaxRes-1:0]  res;
  } src_item_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [7:0] char_code = 8'h00;
  logic       end_of_input = 1'b0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [1:0] item_kind;
  logic [7:0] token_char;
  logic [3:0] token_type;
  logic [1:0] error_kind;
  logic       last;

  src_item_t source_q[$];
  lex_res_t  tokens_due[$];
  lex_res_t  step_res[$];
  mode_t     shadow_mode = MODE_IDLE;

  int n_fail = 0;
  int n_checked = 0;
  int n_ends = 0;
  int n_errs = 0;
  int n_eoi = 0;
  int max_step = 0;

  int tx_idx = 0;
  int tx_burst = 1;
  int tx_gap = 0;
  logic tx_hold;
  logic tx_next_valid;

  int rx_style = 0;
  int rx_left = 0;
  int rx_tick = 0;

  lex_res_t mon_res;

  always #6 clk = ~clk;

  smalltalk_token_lexer u_top (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .char_code    (char_code),
    .end_of_input (end_of_input),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .item_kind    (item_kind),
    .token_char   (token_char),
    .token_type   (token_type),
    .error_kind   (error_kind),
    .last         (last)
  );

  // ---------------------------------------------------------------------------
  // character classes
  // ---------------------------------------------------------------------------
  function automatic logic letter_c(logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction

  function automatic logic digit_c(logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic logic blank_c(logic [7:0] c);
    return c == " " || (c >= 8'd9 && c <= 8'd13);
  endfunction

  // selector characters; minus and equal count too
  function automatic logic binop_c(logic [7:0] c);
    case (c)
      "!", "%", "&", "*", "+", ",", "/", "<", "=", ">", "?", "@", "\\", "|", "~", "-":
        return 1'b1;
      default: return 1'b0;
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // scanner prediction: fills step_res and moves shadow_mode
  // ---------------------------------------------------------------------------
  function automatic lex_res_t x_char(logic [7:0] c);
    lex_res_t r;
    r = '0;
    r.kind = KIND_CHAR;
    r.ch = c;
    return r;
  endfunction

  function automatic lex_res_t x_end(tok_t t);
    lex_res_t r;
    r = '0;
    r.kind = KIND_END;
    r.ttype = t;
    return r;
  endfunction

  function automatic lex_res_t x_err(err_t e);
    lex_res_t r;
    r = '0;
    r.kind = KIND_ERR;
    r.err = e;
    return r;
  endfunction

  // a character seen between tokens
  function automatic void open_token(logic [7:0] c);
    tok_t t;
    logic one_char;
    one_char = 1'b1;
    t = TOK_END;
    case (c)
      CH_CARET:  t = TOK_RETURN;
      CH_LBRACK: t = TOK_LBRACK;
      CH_RBRACK: t = TOK_RBRACK;
      CH_LPAREN: t = TOK_LPAREN;
      CH_RPAREN: t = TOK_RPAREN;
      CH_PERIOD: t = TOK_PERIOD;
      CH_SEMI:   t = TOK_SEMI;
      default:   one_char = 1'b0;
    endcase
    shadow_mode = MODE_IDLE;
    if (blank_c(c)) begin
      shadow_mode = MODE_IDLE;
    end else if (c == CH_DQUOTE) begin
      shadow_mode = MODE_COMMENT;
    end else if (letter_c(c)) begin
      step_res.push_back(x_char(c));
      shadow_mode = MODE_IDENT;
    end else if (digit_c(c)) begin
      step_res.push_back(x_char(c));
      shadow_mode = MODE_NUMBER;
    end else if (c == CH_DOLLAR) begin
      shadow_mode = MODE_CHARLIT;
    end else if (c == CH_SQUOTE) begin
      shadow_mode = MODE_STRING;
    end else if (c == CH_COLON) begin
      step_res.push_back(x_char(c));
      shadow_mode = MODE_COLON;
    end else if (one_char) begin
      step_res.push_back(x_char(c));
      step_res.push_back(x_end(t));
    end else if (c == CH_MINUS) begin
      step_res.push_back(x_char(c));
      shadow_mode = MODE_MINUS;
    end else if (binop_c(c)) begin
      step_res.push_back(x_char(c));
      shadow_mode = MODE_BINARY;
    end else begin
      step_res.push_back(x_err(ERR_INVALID));
      shadow_mode = MODE_ERROR;
    end
  endfunction

  // the pending token closes and the same character starts over
  function automatic void close_reopen(tok_t t, logic [7:0] c);
    step_res.push_back(x_end(t));
    open_token(c);
  endfunction

  function automatic void lexer_next(logic eoi, logic [7:0] c);
    lex_res_t r;
    step_res = {};
    if (eoi) begin
      case (shadow_mode)
        MODE_IDENT: begin
          step_res.push_back(x_end(TOK_IDENT));
          step_res.push_back(x_end(TOK_END));
        end
        MODE_NUMBER: begin
          step_res.push_back(x_end(TOK_NUMBER));
          step_res.push_back(x_end(TOK_END));
        end
        MODE_CHARLIT: step_res.push_back(x_err(ERR_CHARLIT));
        MODE_STRING:  step_res.push_back(x_err(ERR_STRLIT));
        MODE_SQUOTE: begin
          step_res.push_back(x_end(TOK_STRING));
          step_res.push_back(x_end(TOK_END));
        end
        MODE_COLON: begin
          step_res.push_back(x_end(TOK_COLON));
          step_res.push_back(x_end(TOK_END));
        end
        MODE_BINARY, MODE_MINUS: begin
          step_res.push_back(x_end(TOK_BINARY));
          step_res.push_back(x_end(TOK_END));
        end
        MODE_ERROR: ;
        // idle and comment both just end the source
        default: step_res.push_back(x_end(TOK_END));
      endcase
      shadow_mode = MODE_IDLE;
    end else begin
      case (shadow_mode)
        MODE_IDENT: begin
          if (letter_c(c) || digit_c(c)) begin
            step_res.push_back(x_char(c));
          end else if (c == CH_COLON) begin
            step_res.push_back(x_char(c));
            step_res.push_back(x_end(TOK_KEYWORD));
            shadow_mode = MODE_IDLE;
          end else begin
            close_reopen(TOK_IDENT, c);
          end
        end
        MODE_NUMBER: begin
          if (letter_c(c) || digit_c(c)) step_res.push_back(x_char(c));
          else close_reopen(TOK_NUMBER, c);
        end
        MODE_CHARLIT: begin
          step_res.push_back(x_char(c));
          step_res.push_back(x_end(TOK_CHAR));
          shadow_mode = MODE_IDLE;
        end
        MODE_STRING: begin
          if (c == CH_SQUOTE) shadow_mode = MODE_SQUOTE;
          else step_res.push_back(x_char(c));
        end
        // a quote inside a string: a second quote is an escaped one
        MODE_SQUOTE: begin
          if (c == CH_SQUOTE) begin
            step_res.push_back(x_char(c));
            shadow_mode = MODE_STRING;
          end else begin
            close_reopen(TOK_STRING, c);
          end
        end
        MODE_COLON: begin
          if (c == CH_EQUAL) begin
            step_res.push_back(x_char(c));
            step_res.push_back(x_end(TOK_ASSIGN));
            shadow_mode = MODE_IDLE;
          end else begin
            close_reopen(TOK_COLON, c);
          end
        end
        MODE_MINUS: begin
          if (digit_c(c)) begin
            step_res.push_back(x_char(c));
            shadow_mode = MODE_NUMBER;
          end else if (binop_c(c)) begin
            step_res.push_back(x_char(c));
            step_res.push_back(x_end(TOK_BINARY));
            shadow_mode = MODE_IDLE;
          end else begin
            close_reopen(TOK_BINARY, c);
          end
        end
        MODE_BINARY: begin
          if (binop_c(c)) begin
            step_res.push_back(x_char(c));
            step_res.push_back(x_end(TOK_BINARY));
            shadow_mode = MODE_IDLE;
          end else begin
            close_reopen(TOK_BINARY, c);
          end
        end
        MODE_COMMENT: begin
          if (c == CH_DQUOTE) shadow_mode = MODE_IDLE;
        end
        MODE_ERROR: ;
        default: open_token(c);
      endcase
    end
    if (step_res.size() > 0) begin
      r = step_res.pop_back();
      r.last = 1'b1;
      step_res.push_back(r);
    end
  endfunction

  // ---------------------------------------------------------------------------
  // source construction
  // ---------------------------------------------------------------------------
  function automatic src_item_t chr(logic [7:0] c);
    src_item_t s;
    s = '0;
    s.ch = c;
    return s;
  endfunction

  function automatic src_item_t eoi_row();
    src_item_t s;
    s = '0;
    s.eoi = 1'b1;
    return s;
  endfunction

  // attach typed-in results; the final one carries the last flag
  function automatic src_item_t fix(src_item_t s, int n, lex_res_t r0, lex_res_t r1,
                                    lex_res_t r2);
    if (n == 1) r0.last = 1'b1;
    if (n == 2) r1.last = 1'b1;
    if (n == 3) r2.last = 1'b1;
    s.fixed = 1'b1;
    s.nres = 2'(n);
    s.res = {r2, r1, r0};
    return s;
  endfunction

  function automatic logic [7:0] pick(string s);
    return s[$urandom_range(0, s.len() - 1)];
  endfunction

  function automatic logic [7:0] rand_letter();
    return ($urandom_range(0, 1) == 1) ? 8'("a" + $urandom_range(0, 25))
                                       : 8'("A" + $urandom_range(0, 25));
  endfunction

  function automatic logic [7:0] rand_alnum();
    return ($urandom_range(0, 2) == 0) ? 8'("0" + $urandom_range(0, 9)) : rand_letter();
  endfunction

  // mostly printable, now and then any byte at all
  function automatic logic [7:0] rand_text();
    return ($urandom_range(0, 2) == 0) ? 8'($urandom_range(0, 255))
                                       : 8'($urandom_range(32, 126));
  endfunction

  function automatic logic [7:0] rand_blank();
    return ($urandom_range(0, 2) == 0) ? 8'($urandom_range(9, 13)) : 8'h20;
  endfunction

  function automatic void add_ch(logic [7:0] c);
    source_q.push_back(chr(c));
  endfunction

  // one random source text ending in an end mark
  function automatic void add_source();
    int ntok;
    int sel;
    logic [7:0] c;
    ntok = $urandom_range(1, 10);
    for (int k = 0; k < ntok; k++) begin
      sel = $urandom_range(0, 99);
      if (sel < 18) begin
        add_ch(rand_letter());
        repeat ($urandom_range(0, 3)) add_ch(rand_alnum());
        if ($urandom_range(0, 3) == 0) add_ch(CH_COLON);
      end else if (sel < 28) begin
        if ($urandom_range(0, 2) == 0) add_ch(CH_MINUS);
        add_ch(8'("0" + $urandom_range(0, 9)));
        repeat ($urandom_range(0, 2)) add_ch(rand_alnum());
      end else if (sel < 34) begin
        add_ch(CH_DOLLAR);
        add_ch(8'($urandom_range(0, 255)));
      end else if (sel < 43) begin
        add_ch(CH_SQUOTE);
        repeat ($urandom_range(0, 4)) begin
          c = ($urandom_range(0, 4) == 0) ? CH_SQUOTE : rand_text();
          add_ch(c);
          if (c == CH_SQUOTE) add_ch(CH_SQUOTE);
        end
        add_ch(CH_SQUOTE);
      end else if (sel < 57) begin
        add_ch(pick("^[]().;"));
      end else if (sel < 62) begin
        add_ch(CH_COLON);
        if ($urandom_range(0, 1) == 1) add_ch(CH_EQUAL);
      end else if (sel < 72) begin
        repeat ($urandom_range(1, 2)) add_ch(pick("!%&*+,/<=>?@\\|~-"));
      end else if (sel < 80) begin
        add_ch(CH_DQUOTE);
        repeat ($urandom_range(0, 3)) begin
          c = rand_text();
          if (c != CH_DQUOTE) add_ch(c);
        end
        add_ch(CH_DQUOTE);
      end else begin
        repeat ($urandom_range(1, 2)) add_ch(rand_blank());
      end
    end
    // a tail of noise, or a literal or comment left open at the end mark
    sel = $urandom_range(0, 9);
    if (sel == 0) begin
      repeat ($urandom_range(1, 4)) add_ch(8'($urandom_range(0, 255)));
    end else if (sel == 1) begin
      case ($urandom_range(0, 2))
        0: add_ch(CH_DOLLAR);
        1: begin
          add_ch(CH_SQUOTE);
          repeat ($urandom_range(0, 3)) add_ch(rand_letter());
        end
        default: begin
          add_ch(CH_DQUOTE);
          repeat ($urandom_range(0, 3)) add_ch(rand_letter());
        end
      endcase
    end
    source_q.push_back(eoi_row());
    source_q[source_q.size() - 1].ch = 8'($urandom_range(0, 255));
  endfunction

  function automatic void check_field(string name, int want, int got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      n_fail++;
    end
  endfunction

  // ---------------------------------------------------------------------------
  // sender: bursts of random length, random gaps in between
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      tx_hold = in_valid;
      if (in_valid && in_ready) begin
        tx_hold = 1'b0;
        lexer_next(source_q[tx_idx].eoi, source_q[tx_idx].ch);
        if (source_q[tx_idx].eoi) n_eoi++;
        if (step_res.size() > max_step) max_step = step_res.size();
        if (source_q[tx_idx].fixed) begin
          for (int i = 0; i < source_q[tx_idx].nres; i++)
            tokens_due.push_back(source_q[tx_idx].res[i]);
        end else begin
          foreach (step_res[i]) tokens_due.push_back(step_res[i]);
        end
        tx_idx++;
      end
      // a pending transaction holds valid and payload untouched
      if (!tx_hold) begin
        tx_next_valid = 1'b0;
        if (tx_gap > 0) begin
          tx_gap--;
        end else if (tx_idx < source_q.size()) begin
          tx_next_valid = 1'b1;
          char_code <= source_q[tx_idx].ch;
          end_of_input <= source_q[tx_idx].eoi;
          tx_burst--;
          if (tx_burst <= 0) begin
            tx_gap = $urandom_range(1, 7);
            tx_burst = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120)
                                                   : $urandom_range(1, 12);
          end
        end
        in_valid <= tx_next_valid;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // receiver: always ready, coin toss, or one cycle in four, in stretches
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (rx_left == 0) begin
        rx_style = $urandom_range(0, 2);
        rx_left = $urandom_range(20, 80);
      end
      rx_left--;
      rx_tick++;
      case (rx_style)
        0:       out_ready <= 1'b1;
        1:       out_ready <= 1'($urandom_range(0, 1));
        default: out_ready <= (rx_tick % 4 == 0);
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // result checking, oldest expectation first
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (tokens_due.size() == 0) begin
        $error("unexpected result: item_kind %0d token_char %0d token_type %0d",
               item_kind, token_char, token_type);
        n_fail++;
      end else begin
        mon_res = tokens_due.pop_front();
        check_field("item_kind", mon_res.kind, item_kind);
        check_field("token_char", mon_res.ch, token_char);
        check_field("token_type", mon_res.ttype, token_type);
        check_field("error_kind", mon_res.err, error_kind);
        check_field("last", mon_res.last, last);
        n_checked++;
        if (mon_res.kind == KIND_END) n_ends++;
        if (mon_res.kind == KIND_ERR) n_errs++;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus and end of run
  // ---------------------------------------------------------------------------
  initial begin
    int n_dir;
    // directed rows: typed-in results where they are plain to see
    source_q.push_back(fix(eoi_row(), 1, x_end(TOK_END), '0, '0));       // end right after reset
    source_q.push_back(chr("x"));
    source_q.push_back(chr(CH_COLON));                                    // keyword
    source_q.push_back(chr(CH_MINUS));
    source_q.push_back(chr("7"));                                         // negative number
    source_q.push_back(chr("Z"));
    source_q.push_back(eoi_row());                                        // pending number closed
    source_q.push_back(chr(CH_DOLLAR));
    source_q.push_back(fix(chr(8'hFF), 2, x_char(8'hFF), x_end(TOK_CHAR), '0));
    source_q.push_back(chr(CH_SQUOTE));
    source_q.push_back(chr(CH_SQUOTE));                                   // empty string
    source_q.push_back(chr(CH_LPAREN));                                   // three results
    source_q.push_back(chr(CH_DQUOTE));
    source_q.push_back(fix(eoi_row(), 1, x_end(TOK_END), '0, '0));       // end inside comment
    source_q.push_back(chr(CH_SQUOTE));
    source_q.push_back(chr("q"));
    source_q.push_back(fix(eoi_row(), 1, x_err(ERR_STRLIT), '0, '0));    // open string
    source_q.push_back(chr(CH_DOLLAR));
    source_q.push_back(fix(eoi_row(), 1, x_err(ERR_CHARLIT), '0, '0));   // open char literal
    source_q.push_back(chr(CH_COLON));
    source_q.push_back(chr(CH_EQUAL));                                    // assign
    source_q.push_back(chr("<"));
    source_q.push_back(chr(CH_EQUAL));                                    // two-char selector
    source_q.push_back(fix(chr(8'h00), 1, x_err(ERR_INVALID), '0, '0));  // NUL is invalid
    source_q.push_back(fix(chr(CH_CARET), 0, '0, '0, '0));               // swallowed after error
    source_q.push_back(fix(eoi_row(), 0, '0, '0, '0));                   // end after error is silent
    n_dir = source_q.size();

    // random sources fill the run up to about 380 transactions in all
    while (source_q.size() < 380) add_source();

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    while (tx_idx < source_q.size() || tokens_due.size() != 0) @(posedge clk);
    // room for anything extra the block might still send
    repeat (20) @(posedge clk);

    if (tokens_due.size() != 0) begin
      $error("%0d results never arrived", tokens_due.size());
      n_fail++;
    end

    $display("%0d input transactions sent (%0d directed, %0d end marks), %0d results checked",
             source_q.size(), n_dir, n_eoi, n_checked);
    $display("token ends %0d, errors %0d, most results from one transaction %0d",
             n_ends, n_errs, max_step);
    if (n_fail == 0) begin
      $display("smalltalk_token_lexer_tb passed");
    end else begin
      $display("smalltalk_token_lexer_tb failed");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("smalltalk_token_lexer_tb failed");
    $finish;
  end

endmodule
